### rtl/wec_pkg.sv
// ----------------------------------------------------------------------------
// wec_pkg: shared types and constants
// Widths, register indexes, event kinds and payload structs.
// ----------------------------------------------------------------------------
package wec_pkg;

  localparam int unsigned DirSlotsDefault = 64;
  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

  localparam logic [15:0] ShortWinReset = 16'd10;
  localparam logic [15:0] LongWinReset  = 16'd30;

  typedef enum logic [2:0] {
    KIND_OPEN     = 3'd0,
    KIND_WRITE    = 3'd1,
    KIND_TRUNCATE = 3'd2,
    KIND_RENAME   = 3'd3,
    KIND_DELETE   = 3'd4,
    KIND_CLOSE    = 3'd5,
    KIND_OTHER    = 3'd6,
    KIND_UNUSED   = 3'd7
  } kind_t;

  localparam logic [0:0] REG_SHORT_WIN = 1'b0;
  localparam logic [0:0] REG_LONG_WIN  = 1'b1;

  typedef struct packed {
    logic [31:0] now;
    logic [2:0]  req_type;
    logic        risky;
    logic        ransom_ext;
    logic        ext_change;
    logic        content_same;
    logic        high_entropy;
    logic        sig_match;
    logic [63:0] dir_tag;
  } event_t;

  typedef struct packed {
    logic [31:0] modified_total;
    logic [31:0] rename_total;
    logic [31:0] delete_total;
    logic [31:0] ext_change_total;
    logic [31:0] ransom_ext_total;
    logic [31:0] entropy_total;
    logic [31:0] match_total;
    logic [31:0] same_content_total;
    logic [31:0] dirs_touched;
    logic [31:0] events_seen;
  } result_t;

  typedef struct packed {
    logic [0:0]  index;
    logic        index_ok;
    logic [15:0] data;
  } cfg_t;

  // directory search control between sequencer and set
  typedef struct packed {
    logic start;
    logic clear;
    logic insert;
  } dir_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
    logic full;
  } dir_sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c, input logic en);
    return (en && c != CntMax) ? c + 32'd1 : c;
  endfunction

  function automatic logic expired(input logic [31:0] now, input logic [31:0] start,
                                   input logic [15:0] len);
    logic [31:0] diff;
    diff = now - start;
    return (now >= start) && (diff >= {16'd0, len});
  endfunction

endpackage

### rtl/wec_if.sv
// ----------------------------------------------------------------------------
// wec_if: valid/ready channels
// Event, result and configuration write channels.
// ----------------------------------------------------------------------------
interface wec_event_if import wec_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wec_result_if import wec_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wec_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wec_dir_set.sv
// ----------------------------------------------------------------------------
// wec_dir_set: directory hash set
// Walks stored hashes one per cycle through one shared comparator.
// ----------------------------------------------------------------------------
module wec_dir_set import wec_pkg::*; #(
  parameter int unsigned DIR_SLOTS = DirSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  dir_ctl_t    ctl,
  input  logic [63:0] hash,
  output dir_sts_t    sts
);
  localparam int unsigned IW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int unsigned FW = $clog2(DIR_SLOTS + 1);

  logic [63:0]   mem [DIR_SLOTS];
  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic          busy;
  logic          done;
  logic          found;
  logic          rd_valid;
  logic [63:0]   rd_data;

  always_ff @(posedge clk) begin
    if (idx < fill) rd_data <= mem[idx[IW-1:0]];
    if (ctl.insert && fill < FW'(DIR_SLOTS)) mem[fill[IW-1:0]] <= hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx <= '0;
      busy <= 1'b0;
      done <= 1'b0;
      found <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.clear) fill <= '0;
      else if (ctl.insert && fill < FW'(DIR_SLOTS)) fill <= fill + 1'b1;
      if (ctl.start) begin
        busy <= 1'b1;
        found <= 1'b0;
        idx <= '0;
        rd_valid <= 1'b0;
      end else if (busy) begin
        if (rd_valid && rd_data == hash) found <= 1'b1;
        if (idx < fill) begin
          rd_valid <= 1'b1;
          idx <= idx + 1'b1;
        end else begin
          rd_valid <= 1'b0;
          if (!rd_valid) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign sts.found = found;
  assign sts.full  = (fill >= FW'(DIR_SLOTS));
endmodule

### rtl/windowed_event_counters.sv
// ----------------------------------------------------------------------------
// windowed_event_counters: per-session file activity accounting
// Window checks, per-kind counters and a deduplicated directory set.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one file event per item; res returns one item of all
//   counters per event; cfg writes register 0 (short window) or 1 (long
//   window), taken whenever the block is idle.
//   The directory search reads one stored hash per cycle from the set
//   memory through a single comparator and walks only the filled slots.
//   evt.ready is high only while no event is in work and no result waits.
//   The next event can be taken in the cycle after the result is
//   accepted, so a new event is taken only once the last one is through.
//   A stalled receiver holds the result; the next event waits behind it.
//   Reset (rst, synchronous) clears all counters, window starts, the set
//   fill and restores window lengths 10 and 30; no clearing pass.
// ----------------------------------------------------------------------------
module windowed_event_counters import wec_pkg::*; #(
  parameter int unsigned DIR_SLOTS = DirSlotsDefault
) (
  input logic clk,
  input logic rst,
  wec_event_if.sink    evt,
  wec_result_if.source res,
  wec_cfg_if.sink      cfg
);
  typedef enum logic [2:0] {S_IDLE, S_WIN, S_SEARCH, S_WAIT, S_OUT} state_t;

  state_t      state;
  event_t      ev;
  logic [15:0] short_win, long_win;
  logic [31:0] modified_cnt, rename_cnt, delete_cnt, extchg_cnt;
  logic [31:0] ransom_cnt, entropy_cnt, match_cnt, same_cnt;
  logic [31:0] short_start, long_start, touched_cnt, event_cnt;
  dir_ctl_t    dctl;
  dir_sts_t    dsts;
  logic [31:0] ss, ls;
  logic        kmod;
  logic        retract;

  wec_dir_set #(.DIR_SLOTS(DIR_SLOTS)) u_set (
    .clk(clk), .rst(rst), .ctl(dctl), .hash(ev.dir_tag), .sts(dsts));

  assign ss = (short_start == '0) ? ev.now : short_start;
  assign ls = (long_start == '0) ? ev.now : long_start;
  assign kmod = (ev.req_type == KIND_OPEN) || (ev.req_type == KIND_WRITE) ||
                (ev.req_type == KIND_TRUNCATE);
  assign retract = (ev.req_type == KIND_CLOSE) && ev.content_same &&
                   (modified_cnt != '0);

  assign evt.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.data = '{modified_cnt, rename_cnt, delete_cnt, extchg_cnt, ransom_cnt,
                      entropy_cnt, match_cnt, same_cnt, touched_cnt, event_cnt};

  always_comb begin
    dctl = '0;
    dctl.clear  = (state == S_WIN) && expired(ev.now, ls, long_win);
    dctl.start  = (state == S_WIN);
    dctl.insert = (state == S_WAIT) && dsts.done && !dsts.found && !dsts.full &&
                  (ev.dir_tag != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      short_win <= ShortWinReset;
      long_win <= LongWinReset;
      {modified_cnt, rename_cnt, delete_cnt, extchg_cnt} <= '0;
      {ransom_cnt, entropy_cnt, match_cnt, same_cnt} <= '0;
      {short_start, long_start, touched_cnt, event_cnt} <= '0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index[31:1] == '0) begin
        if (cfg.index[0] == REG_SHORT_WIN) short_win <= cfg.data;
        else long_win <= cfg.data;
      end
      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            ev <= evt.data;
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (expired(ev.now, ss, short_win)) begin
            {modified_cnt, rename_cnt, delete_cnt, extchg_cnt} <= '0;
            {ransom_cnt, entropy_cnt, match_cnt, same_cnt} <= '0;
            short_start <= ev.now;
          end else begin
            short_start <= ss;
          end
          if (expired(ev.now, ls, long_win)) begin
            touched_cnt <= '0;
            long_start <= ev.now;
          end else begin
            long_start <= ls;
          end
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          modified_cnt <= retract ? modified_cnt - 32'd1 :
                          sat_inc(modified_cnt, kmod && ev.risky);
          ransom_cnt <= sat_inc(ransom_cnt,
            (kmod || ev.req_type == KIND_RENAME) && ev.ransom_ext);
          rename_cnt <= sat_inc(rename_cnt, ev.req_type == KIND_RENAME);
          extchg_cnt <= sat_inc(extchg_cnt, ev.req_type == KIND_RENAME && ev.ext_change);
          delete_cnt <= sat_inc(delete_cnt, ev.req_type == KIND_DELETE);
          same_cnt <= sat_inc(same_cnt, retract);
          entropy_cnt <= sat_inc(entropy_cnt, ev.high_entropy);
          match_cnt <= sat_inc(match_cnt, ev.sig_match);
          event_cnt <= event_cnt + 32'd1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (dsts.done) begin
            touched_cnt <= sat_inc(touched_cnt, dctl.insert);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> !evt.ready) else $error("accepted while busy");
  a_hold_res: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.data)))
    else $error("result dropped under stall");
  a_evt_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready) |=> $stable(res.data.events_seen))
    else $error("event count moved without event");
endmodule

### tb/sv/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker: file activity counter scoreboard
// Watches event, result and configuration channels, keeps its own model of
// the windowed counters and directory set, and compares every result.
// ----------------------------------------------------------------------------
module tb_checker import wec_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  wec_event_if.sink       evt,
  wec_result_if.sink      res,
  wec_cfg_if.sink         cfg,
  output int              fail_count,
  output int              pending
);

  logic [15:0] short_len, long_len;
  logic [31:0] mod_n, ren_n, del_n, extc_n, ransom_n, ent_n, match_n, same_n;
  logic [31:0] short_t0, long_t0, touched_n, event_n;
  logic [63:0] dirs[$];
  result_t     expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c != CntMax) ? c + 32'd1 : c;
  endfunction

  function automatic logic win_over(input logic [31:0] now, input logic [31:0] t0,
                                    input logic [15:0] len);
    return (now >= t0) && ((now - t0) >= {16'd0, len});
  endfunction

  task automatic apply_event(input event_t e);
    result_t r;
    logic    seen;
    if (short_t0 == 0) short_t0 = e.now;
    if (long_t0 == 0) long_t0 = e.now;
    if (win_over(e.now, short_t0, short_len)) begin
      {mod_n, ren_n, del_n, extc_n, ransom_n, ent_n, match_n, same_n} = '0;
      short_t0 = e.now;
    end
    if (win_over(e.now, long_t0, long_len)) begin
      touched_n = 0;
      dirs.delete();
      long_t0 = e.now;
    end
    case (kind_t'(e.req_type))
      KIND_OPEN, KIND_WRITE, KIND_TRUNCATE: begin
        if (e.risky) mod_n = bump(mod_n);
        if (e.ransom_ext) ransom_n = bump(ransom_n);
      end
      KIND_RENAME: begin
        ren_n = bump(ren_n);
        if (e.ext_change) extc_n = bump(extc_n);
        if (e.ransom_ext) ransom_n = bump(ransom_n);
      end
      KIND_DELETE: del_n = bump(del_n);
      KIND_CLOSE: begin
        if (e.content_same && mod_n != 0) begin
          mod_n = mod_n - 1;
          same_n = bump(same_n);
        end
      end
      default: ;
    endcase
    if (e.high_entropy) ent_n = bump(ent_n);
    if (e.sig_match) match_n = bump(match_n);
    seen = 0;
    foreach (dirs[i]) if (dirs[i] == e.dir_tag) seen = 1;
    if (e.dir_tag != 0 && !seen && dirs.size() < DirSlotsDefault) begin
      dirs.push_back(e.dir_tag);
      touched_n = bump(touched_n);
    end
    event_n = event_n + 1;
    r = '{mod_n, ren_n, del_n, extc_n, ransom_n, ent_n, match_n, same_n,
          touched_n, event_n};
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t x;
    if (rst) begin
      short_len <= ShortWinReset;
      long_len  <= LongWinReset;
      {mod_n, ren_n, del_n, extc_n, ransom_n, ent_n, match_n, same_n} = '0;
      {short_t0, long_t0, touched_n, event_n} = '0;
      dirs.delete();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == 32'(REG_SHORT_WIN)) short_len <= cfg.data;
        else if (cfg.index == 32'(REG_LONG_WIN)) long_len <= cfg.data;
      end
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no event pending");
          fail_count++;
        end else begin
          x = expected_q.pop_front();
          compare_field("modified_total", x.modified_total, res.data.modified_total);
          compare_field("rename_total", x.rename_total, res.data.rename_total);
          compare_field("delete_total", x.delete_total, res.data.delete_total);
          compare_field("ext_change_total", x.ext_change_total,
                        res.data.ext_change_total);
          compare_field("ransom_ext_total", x.ransom_ext_total,
                        res.data.ransom_ext_total);
          compare_field("entropy_total", x.entropy_total, res.data.entropy_total);
          compare_field("match_total", x.match_total, res.data.match_total);
          compare_field("same_content_total", x.same_content_total,
                        res.data.same_content_total);
          compare_field("dirs_touched", x.dirs_touched, res.data.dirs_touched);
          compare_field("events_seen", x.events_seen, res.data.events_seen);
        end
      end
      if (evt.valid && evt.ready) apply_event(evt.data);
    end
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: windowed event counter testbench
// Directed corner events, then random sessions of file events with a small
// pool of directory hashes, under three idling mixes and several window
// settings; results are checked by tb_checker.
// ----------------------------------------------------------------------------
module tb_top import wec_pkg::*;;

  localparam int WatchLimit = 20000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  int   send_idle, recv_idle;
  int   quiet;
  logic [31:0] clock_now;
  logic [63:0] hash_pool[16];

  wec_event_if  evt ();
  wec_result_if res ();
  wec_cfg_if    cfg ();

  windowed_event_counters DUT (.clk(clk), .rst(rst), .evt(evt), .res(res), .cfg(cfg));
  tb_checker u_checker (.clk(clk), .rst(rst), .evt(evt), .res(res), .cfg(cfg),
                        .fail_count(fail_count), .pending(pending));

  always #4 clk = ~clk;

  initial begin
    evt.valid = 0;
    evt.data  = '0;
    res.ready = 0;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data  = '0;
  end

  always @(posedge clk) begin
    if (!rst) res.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_event(input event_t e);
    if ($urandom_range(99) < send_idle) begin
      evt.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    evt.valid <= 1;
    evt.data  <= e;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [31:0] idx, input logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic drain();
    evt.valid <= 0;
    while (pending != 0 || evt.valid) @(posedge clk);
    repeat (DirSlotsDefault + 10) @(posedge clk);
  endtask

  function automatic event_t make_event(input logic [2:0] k, input logic [5:0] flags,
                                        input logic [31:0] now, input logic [63:0] h);
    event_t e;
    e.now = now;
    e.req_type = k;
    {e.risky, e.ransom_ext, e.ext_change, e.content_same, e.high_entropy,
     e.sig_match} = flags;
    e.dir_tag = h;
    return e;
  endfunction

  function automatic event_t random_event();
    logic [63:0] h;
    int sel;
    sel = $urandom_range(9);
    clock_now = clock_now + $urandom_range(3);
    if (sel == 0) h = 0;
    else if (sel < 7) h = hash_pool[$urandom_range(15)];
    else h = {$urandom, $urandom};
    return make_event(3'($urandom_range(7)), 6'($urandom), clock_now, h);
  endfunction

  initial begin
    logic [15:0] short_set[5];
    logic [15:0] long_set[5];
    short_set = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd8};
    long_set  = '{16'd65535, 16'd0, 16'd20, 16'd5, 16'd40};
    foreach (hash_pool[i]) hash_pool[i] = {$urandom, $urandom};
    hash_pool[0] = '1;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_event(make_event(KIND_OPEN, 6'b111111, 32'd0, 64'd0));
    send_event(make_event(KIND_WRITE, 6'b100000, 32'd5, 64'd1));
    send_event(make_event(KIND_TRUNCATE, 6'b110011, 32'd6, '1));
    send_event(make_event(KIND_RENAME, 6'b011000, 32'd7, '1));
    send_event(make_event(KIND_RENAME, 6'b000000, 32'd7, 64'd1));
    send_event(make_event(KIND_DELETE, 6'b111111, 32'd8, 64'd2));
    send_event(make_event(KIND_CLOSE, 6'b000100, 32'd9, 64'd0));
    send_event(make_event(KIND_CLOSE, 6'b000100, 32'd9, 64'd0));
    send_event(make_event(KIND_CLOSE, 6'b000100, 32'd9, 64'd0));
    send_event(make_event(KIND_OTHER, 6'b111111, 32'd3, 64'd3));
    send_event(make_event(KIND_UNUSED, 6'b111111, 32'd20, 64'd3));
    send_event(make_event(KIND_WRITE, 6'b100000, 32'd60, 64'd4));
    send_event(make_event(KIND_WRITE, 6'b100000, '1, 64'd5));
    send_event(make_event(KIND_OPEN, 6'b100000, 32'd100, 64'd6));
    for (int i = 0; i < 66; i++)
      send_event(make_event(KIND_OTHER, 6'b000000, 32'd100, 64'd1000 + i));

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(32'(REG_SHORT_WIN), short_set[p % 5]);
      write_reg(32'(REG_LONG_WIN), long_set[p % 5]);
      cfg.valid <= 0;
      if (p < 2) begin
        send_idle = 17;
        recv_idle = 80;
      end else if (p < 4) begin
        send_idle = 80;
        recv_idle = 17;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      clock_now = (p == 5) ? 32'hFFFF_FF00 : $urandom_range(1000);
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(19) == 0) clock_now = clock_now - $urandom_range(5);
        send_event(random_event());
      end
    end
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
